[src/bprq_pkg.sv]
// bprq_pkg: shared types and constants for the buffer pool ready queue.
// Holds the operation and status codes and the request/result structs.
// No dependencies.
`default_nettype none

package bprq_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned ID_W     = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 4;

  localparam logic [ID_W-1:0] NONE_ID = 8'hFF;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_MARK    = 2'd1,
    OP_TAKE    = 2'd2,
    OP_RELEASE = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK            = 3'd0,
    ST_DATA_AVAIL    = 3'd1,
    ST_NO_BUFFER     = 3'd2,
    ST_OUT_OF_RANGE  = 3'd3,
    ST_DOUBLE_MARK   = 3'd4,
    ST_EARLY_RELEASE = 3'd5,
    ST_NOT_ALLOCATED = 3'd6
  } status_e;

  typedef struct packed {
    op_e              operation;
    logic [ID_W-1:0]  request_id;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [ID_W-1:0]    granted_id;
    logic [COUNT_W-1:0] ready_count;
    logic               any_ready;
  } rsp_t;

endpackage

`default_nettype wire

[src/bprq_req_if.sv]
// bprq_req_if: request channel of the buffer pool ready queue.
// Carries valid/ready and the operation and request id.
// Depends on nothing.
`default_nettype none

interface bprq_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] request_id;

  modport source (output valid, output operation, output request_id, input ready);
  modport sink   (input valid, input operation, input request_id, output ready);
endinterface

`default_nettype wire

[src/bprq_rsp_if.sv]
// bprq_rsp_if: result channel of the buffer pool ready queue.
// Carries valid/ready and status, granted id, ready count and any-ready flag.
// Depends on nothing.
`default_nettype none

interface bprq_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] granted_id;
  logic [3:0] ready_count;
  logic       any_ready;

  modport source (output valid, output status, output granted_id, output ready_count,
                  output any_ready, input ready);
  modport sink   (input valid, input status, input granted_id, input ready_count,
                  input any_ready, output ready);
endinterface

`default_nettype wire

[src/bprq_in_stage.sv]
// bprq_in_stage: input register of the request channel.
// Holds one request until the engine takes it.
// Depends on bprq_pkg.
`default_nettype none

module bprq_in_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  input  wire bprq_pkg::req_t req_i,
  output logic               ready_o,
  input  wire logic          take_i,
  output logic               valid_o,
  output bprq_pkg::req_t     req_o
);

  logic           valid_q, valid_d;
  bprq_pkg::req_t req_q;
  logic           load;

  assign ready_o = !valid_q || take_i;
  assign load    = valid_i && ready_o;
  assign valid_d = load || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      req_q <= req_i;
    end
  end

  assign valid_o = valid_q;
  assign req_o   = req_q;

endmodule

`default_nettype wire

[src/bprq_engine.sv]
// bprq_engine: pool state (free map, ready map, ready FIFO, pointers) and
// the single-pass update logic feeding the result register.
// Depends on bprq_pkg.
`default_nettype none

module bprq_engine #(
  parameter int unsigned NUM_BUFFERS = 8
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  input  wire bprq_pkg::req_t req_i,
  output logic                take_o,
  input  wire logic           rsp_ready_i,
  output logic                rsp_valid_o,
  output bprq_pkg::rsp_t      rsp_o
);

  localparam int unsigned PTR_W = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(NUM_BUFFERS - 1);

  logic [NUM_BUFFERS-1:0] free_q, free_d;
  logic [NUM_BUFFERS-1:0] ready_q, ready_d;
  logic [PTR_W-1:0]       head_q, head_d;
  logic [PTR_W-1:0]       tail_q, tail_d;
  logic [PTR_W-1:0]       ready_fifo [NUM_BUFFERS];

  logic                   res_valid_q, res_valid_d;
  bprq_pkg::rsp_t         rsp_q, rsp_d;

  logic                   take;
  logic                   push;
  logic                   in_range;
  logic [NUM_BUFFERS-1:0] bit_mask;
  logic [NUM_BUFFERS-1:0] low_mask;
  logic [NUM_BUFFERS-1:0] ent_mask;
  logic [bprq_pkg::ID_W-1:0] low_idx;
  logic [PTR_W-1:0]       head_ent_q;
  logic [PTR_W-1:0]       rd_ptr;
  logic                   ready_hit;
  logic                   free_hit;
  logic [bprq_pkg::COUNT_W-1:0] pop_cnt;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    ptr_next = (p == LAST_PTR) ? '0 : p + PTR_W'(1);
  endfunction

  assign take   = valid_i && (!res_valid_q || rsp_ready_i);
  assign take_o = take;

  assign in_range = req_i.request_id < bprq_pkg::ID_W'(NUM_BUFFERS);

  // head entry is prefetched for the pointer the next request will see
  assign rd_ptr = take ? head_d : head_q;

  always_comb begin
    low_idx = '0;
    for (int i = NUM_BUFFERS - 1; i >= 0; i--) begin
      bit_mask[i] = in_range && (req_i.request_id == bprq_pkg::ID_W'(i));
      ent_mask[i] = (head_ent_q == PTR_W'(i));
      if (free_q[i]) begin
        low_idx = bprq_pkg::ID_W'(i);
      end
    end
  end

  // isolate lowest set bit of the free map
  assign low_mask  = free_q & (~free_q + NUM_BUFFERS'(1));
  assign ready_hit = |(ready_q & bit_mask);
  assign free_hit  = |(free_q & bit_mask);

  always_comb begin
    free_d            = free_q;
    ready_d           = ready_q;
    head_d            = head_q;
    tail_d            = tail_q;
    push              = 1'b0;
    rsp_d.status      = bprq_pkg::ST_OK;
    rsp_d.granted_id  = req_i.request_id;
    case (req_i.operation)
      bprq_pkg::OP_ALLOC: begin
        if (free_q == '0) begin
          rsp_d.status     = bprq_pkg::ST_NO_BUFFER;
          rsp_d.granted_id = bprq_pkg::NONE_ID;
        end else begin
          free_d           = free_q & ~low_mask;
          rsp_d.granted_id = low_idx;
        end
      end
      bprq_pkg::OP_MARK: begin
        if (!in_range) begin
          rsp_d.status = bprq_pkg::ST_OUT_OF_RANGE;
        end else if (ready_hit) begin
          rsp_d.status = bprq_pkg::ST_DOUBLE_MARK;
        end else if (!free_hit) begin
          // marking a free id is silently ignored
          ready_d = ready_q | bit_mask;
          push    = 1'b1;
          tail_d  = ptr_next(tail_q);
        end
      end
      bprq_pkg::OP_TAKE: begin
        if (ready_q == '0) begin
          rsp_d.status     = bprq_pkg::ST_NO_BUFFER;
          rsp_d.granted_id = bprq_pkg::NONE_ID;
        end else begin
          head_d           = ptr_next(head_q);
          ready_d          = ready_q & ~ent_mask;
          rsp_d.status     = bprq_pkg::ST_DATA_AVAIL;
          rsp_d.granted_id = bprq_pkg::ID_W'(head_ent_q);
        end
      end
      bprq_pkg::OP_RELEASE: begin
        if (!in_range) begin
          rsp_d.status = bprq_pkg::ST_OUT_OF_RANGE;
        end else if (ready_hit) begin
          rsp_d.status = bprq_pkg::ST_EARLY_RELEASE;
        end else if (!free_hit) begin
          free_d = free_q | bit_mask;
        end else begin
          rsp_d.status = bprq_pkg::ST_NOT_ALLOCATED;
        end
      end
      default: begin
        rsp_d.status = bprq_pkg::ST_OK;
      end
    endcase

    pop_cnt = '0;
    for (int i = 0; i < NUM_BUFFERS; i++) begin
      pop_cnt = pop_cnt + bprq_pkg::COUNT_W'(ready_d[i]);
    end
    rsp_d.ready_count = pop_cnt;
    rsp_d.any_ready   = |ready_d;
  end

  assign res_valid_d = take || (res_valid_q && !rsp_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q      <= '1;
      ready_q     <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      if (take) begin
        free_q  <= free_d;
        ready_q <= ready_d;
        head_q  <= head_d;
        tail_q  <= tail_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      rsp_q <= rsp_d;
    end
    if (take && push) begin
      ready_fifo[tail_q] <= req_i.request_id[PTR_W-1:0];
    end
    // a push into an empty FIFO lands right at the head
    if (take && push && (tail_q == rd_ptr)) begin
      head_ent_q <= req_i.request_id[PTR_W-1:0];
    end else begin
      head_ent_q <= ready_fifo[rd_ptr];
    end
  end

  assign rsp_valid_o = res_valid_q;
  assign rsp_o       = rsp_q;

endmodule

`default_nettype wire

[src/buffer_pool_ready_queue.sv]
// Buffer pool ready queue: allocate, mark ready, take ready, release.
// Path: an accepted request enters the input register, then one pass over the
// pool state, a single registered update, takes it into the result register.
// Throughput: one request per cycle while the result output is not stalled.
// Reset: every buffer free, nothing ready, FIFO pointers zero, both stages empty;
// FIFO entries are not cleared.
`default_nettype none

module buffer_pool_ready_queue #(
  parameter int unsigned NUM_BUFFERS = 8
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  bprq_req_if.sink    req_i,
  bprq_rsp_if.source  rsp_o
);

  bprq_pkg::req_t in_req;
  bprq_pkg::req_t stage_req;
  bprq_pkg::rsp_t rsp;
  logic           stage_valid;
  logic           take;

  assign in_req.operation  = bprq_pkg::op_e'(req_i.operation);
  assign in_req.request_id = req_i.request_id;

  bprq_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (req_i.valid),
    .req_i   (in_req),
    .ready_o (req_i.ready),
    .take_i  (take),
    .valid_o (stage_valid),
    .req_o   (stage_req)
  );

  bprq_engine #(
    .NUM_BUFFERS (NUM_BUFFERS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (stage_valid),
    .req_i       (stage_req),
    .take_o      (take),
    .rsp_ready_i (rsp_o.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_o       (rsp)
  );

  assign rsp_o.status      = rsp.status;
  assign rsp_o.granted_id  = rsp.granted_id;
  assign rsp_o.ready_count = rsp.ready_count;
  assign rsp_o.any_ready   = rsp.any_ready;

endmodule

`default_nettype wire
